### hw/rtl/cesd_pkg.sv
package cesd_pkg;

   localparam int FRAC_BITS = 24;
   localparam int PIPE_DEPTH = 13;
   localparam int LAST_STAGE = PIPE_DEPTH - 1;
   localparam int MUL_LATENCY = 3;
   localparam int N_DELAY = 2 * MUL_LATENCY;
   localparam int C_DELAY = MUL_LATENCY;
   localparam int T_DELAY = 2 * MUL_LATENCY;
   localparam int L_DELAY = MUL_LATENCY;

   typedef logic signed [63:0] q_type;
   typedef logic signed [47:0] o_type;
   typedef logic [1:0] row_type;

   localparam row_type ROW_FIRST = 2'd0;
   localparam row_type ROW_LAST_2D = 2'd1;
   localparam row_type ROW_LAST_3D = 2'd2;

   localparam q_type Q_ONE = q_type'(64'd1 << FRAC_BITS);
   localparam q_type Q_ZERO = 64'sd0;
   localparam q_type Q_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam q_type Q_MIN = 64'shC000_0000_0000_0000;
   localparam logic signed [64:0] W_MAX = 65'sh0_3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [64:0] W_MIN = 65'sh1_C000_0000_0000_0000;
   localparam q_type O_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam q_type O_MIN = 64'shFFFF_8000_0000_0000;
   localparam logic [126:0] MUL_RND = 127'd1 << (FRAC_BITS - 1);

   typedef struct packed {
      q_type s0;
      q_type s1;
      q_type s2;
      q_type e0;
      q_type e1;
      q_type e2;
      q_type mu;
      q_type lam;
      q_type twomu;
      q_type hl;
      logic  dim3;
   } a_type;

   typedef struct packed {
      q_type n0;
      q_type n1;
      q_type n2;
   } n_type;

   typedef struct packed {
      q_type d;
      q_type nn01;
      q_type nn02;
      q_type nn12;
   } c_type;

   typedef struct packed {
      q_type musq;
      q_type tme0;
      q_type tme1;
      q_type tme2;
   } t_type;

   typedef struct packed {
      q_type lnn0;
      q_type lnn1;
      q_type lnn2;
      q_type xd0;
      q_type xd1;
      q_type xd2;
   } l_type;

   typedef struct packed {
      o_type energy;
      o_type g0;
      o_type g1;
      o_type g2;
      o_type h00;
      o_type h11;
      o_type h22;
      o_type h01;
      o_type h02;
      o_type h12;
      o_type bl0;
      o_type bl1;
      o_type bl2;
      logic  dim3;
   } res_type;

   function automatic q_type sat_q(input logic signed [64:0] v);
      q_type r;
      if (v > W_MAX) begin
         r = Q_MAX;
      end else if (v < W_MIN) begin
         r = Q_MIN;
      end else begin
         r = v[63:0];
      end
      return r;
   endfunction

   function automatic q_type sat_add(input q_type a, input q_type b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      return sat_q(s);
   endfunction

   function automatic q_type sat_sub(input q_type a, input q_type b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      return sat_q(s);
   endfunction

   function automatic q_type half_q(input q_type x);
      q_type m;
      q_type r;
      if (!x[63]) begin
         r = (x + 64'sd1) >>> 1;
      end else begin
         m = -x;
         r = -((m + 64'sd1) >>> 1);
      end
      return r;
   endfunction

   function automatic o_type out48(input q_type x);
      o_type r;
      if (x > O_MAX) begin
         r = O_MAX[47:0];
      end else if (x < O_MIN) begin
         r = O_MIN[47:0];
      end else begin
         r = x[47:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/cesd_mul.sv
module cesd_mul
   import cesd_pkg::*;
(
   input  logic  clock,
   input  logic  en,
   input  q_type op_a,
   input  q_type op_b,
   output q_type prod
);

   q_type       ua_in;
   q_type       ub_in;
   logic [62:0] ua_ff;
   logic [62:0] ub_ff;
   logic        neg1_ff;
   logic [63:0] p0_in;
   logic [62:0] p1_in;
   logic [62:0] p2_in;
   logic [61:0] p3_in;
   logic [63:0] p0_ff;
   logic [62:0] p1_ff;
   logic [62:0] p2_ff;
   logic [61:0] p3_ff;
   logic        neg2_ff;
   logic [126:0] full;
   logic         big;
   q_type        mag;
   q_type        prod_in;
   q_type        prod_ff;

   // magnitudes
   assign ua_in = op_a[63] ? -op_a : op_a;
   assign ub_in = op_b[63] ? -op_b : op_b;

   // partial products of the 32-bit low and 31-bit high magnitude slices
   assign p0_in = ua_ff[31:0] * ub_ff[31:0];
   assign p1_in = ua_ff[31:0] * ub_ff[62:32];
   assign p2_in = ua_ff[62:32] * ub_ff[31:0];
   assign p3_in = ua_ff[62:32] * ub_ff[62:32];

   // sum, round, saturate
   always_comb begin
      full = (127'(p3_ff) << 64) + (127'(p1_ff) << 32) + (127'(p2_ff) << 32)
           + 127'(p0_ff) + MUL_RND;
      big = |full[126:FRAC_BITS+62];
      mag = {2'b00, full[FRAC_BITS+61:FRAC_BITS]};
      if (big) begin
         prod_in = neg2_ff ? Q_MIN : Q_MAX;
      end else begin
         prod_in = neg2_ff ? -mag : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff   <= ua_in[62:0];
         ub_ff   <= ub_in[62:0];
         neg1_ff <= op_a[63] ^ op_b[63];
         p0_ff   <= p0_in;
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         p3_ff   <= p3_in;
         neg2_ff <= neg1_ff;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

### hw/rtl/corotational_energy_sigma_derivs_core.sv
// a transaction accepted into stage 0 passes the stage registers into the output buffer
// the single result channel moves one row per cycle unless rsp_stall holds it,
// three rows per element in 3d mode, two in 2d mode; reset clears all valid bits and
// selects 3d mode; the 13-stage multiplier pipeline accepts a new element every cycle
// while rows drain, unless its last stage waits on a full output buffer
module corotational_energy_sigma_derivs_core
   import cesd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_sigma_a,
   input  logic signed [31:0] req_sigma_b,
   input  logic signed [31:0] req_sigma_c,
   input  logic signed [31:0] req_shear_mu,
   input  logic signed [31:0] req_lame_lambda,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_row_index,
   output logic signed [47:0] rsp_energy,
   output logic signed [47:0] rsp_gradient,
   output logic signed [47:0] rsp_hessian_col_a,
   output logic signed [47:0] rsp_hessian_col_b,
   output logic signed [47:0] rsp_hessian_col_c,
   output logic signed [47:0] rsp_bleft_coef,
   output logic               rsp_last_row
);

   logic                  dim3_ff;
   logic                  en;
   logic [LAST_STAGE:0]   v_ff;
   a_type                 a_in;
   a_type                 a_pipe_ff [0:LAST_STAGE];
   a_type                 a3;
   a_type                 a6;
   a_type                 a9;
   a_type                 a12;
   n_type                 n_in;
   n_type                 n_pipe_ff [0:N_DELAY-1];
   c_type                 c_in;
   c_type                 c_pipe_ff [0:C_DELAY-1];
   t_type                 t_in;
   t_type                 t_pipe_ff [0:T_DELAY-1];
   l_type                 l_in;
   l_type                 l_pipe_ff [0:L_DELAY-1];

   q_type p01, n0m, n1m, ee0, ee1, ee2;
   q_type sq;
   q_type prod_m, nn00, nn11, nn22, nn01, nn02, nn12;
   q_type musq, tme0, tme1, tme2, hls2, hls0, hls1;
   q_type d6;
   q_type dd, ld, sd2, sd1, sd0, lnn0, lnn1, lnn2, xd0, xd1, xd2;
   q_type ldd, nld0, nld1, nld2, h01, h02, h12;
   q_type x0_op;
   q_type h01_op;
   res_type               res_in;
   res_type               res_ff;
   logic                  obuf_v_ff;
   row_type               row_ff;
   logic                  rsp_acc;
   logic                  last;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim3_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         dim3_ff <= csr_data;
      end
   end

   // stage 0
   always_comb begin
      a_in.s0    = {{32{req_sigma_a[31]}}, req_sigma_a};
      a_in.s1    = {{32{req_sigma_b[31]}}, req_sigma_b};
      a_in.s2    = {{32{req_sigma_c[31]}}, req_sigma_c};
      a_in.mu    = {{32{req_shear_mu[31]}}, req_shear_mu};
      a_in.lam   = {{32{req_lame_lambda[31]}}, req_lame_lambda};
      a_in.e0    = sat_sub(a_in.s0, Q_ONE);
      a_in.e1    = sat_sub(a_in.s1, Q_ONE);
      a_in.e2    = sat_sub(a_in.s2, Q_ONE);
      a_in.twomu = sat_add(a_in.mu, a_in.mu);
      a_in.hl    = half_q(a_in.lam);
      a_in.dim3  = dim3_ff;
   end

   assign a3  = a_pipe_ff[MUL_LATENCY];
   assign a6  = a_pipe_ff[2*MUL_LATENCY];
   assign a9  = a_pipe_ff[3*MUL_LATENCY];
   assign a12 = a_pipe_ff[4*MUL_LATENCY];

   // round 1
   cesd_mul u_p01 (.clock, .en, .op_a(a_pipe_ff[0].s0), .op_b(a_pipe_ff[0].s1), .prod(p01));
   cesd_mul u_n0m (.clock, .en, .op_a(a_pipe_ff[0].s1), .op_b(a_pipe_ff[0].s2), .prod(n0m));
   cesd_mul u_n1m (.clock, .en, .op_a(a_pipe_ff[0].s2), .op_b(a_pipe_ff[0].s0), .prod(n1m));
   cesd_mul u_ee0 (.clock, .en, .op_a(a_pipe_ff[0].e0), .op_b(a_pipe_ff[0].e0), .prod(ee0));
   cesd_mul u_ee1 (.clock, .en, .op_a(a_pipe_ff[0].e1), .op_b(a_pipe_ff[0].e1), .prod(ee1));
   cesd_mul u_ee2 (.clock, .en, .op_a(a_pipe_ff[0].e2), .op_b(a_pipe_ff[0].e2), .prod(ee2));

   always_comb begin
      n_in.n0 = a3.dim3 ? n0m : a3.s1;
      n_in.n1 = a3.dim3 ? n1m : a3.s0;
      n_in.n2 = a3.dim3 ? p01 : Q_ZERO;
      sq = sat_add(sat_add(ee0, ee1), a3.dim3 ? ee2 : Q_ZERO);
   end

   // round 2
   cesd_mul u_prd  (.clock, .en, .op_a(p01), .op_b(a3.dim3 ? a3.s2 : Q_ONE), .prod(prod_m));
   cesd_mul u_nn00 (.clock, .en, .op_a(n_in.n0), .op_b(n_in.n0), .prod(nn00));
   cesd_mul u_nn11 (.clock, .en, .op_a(n_in.n1), .op_b(n_in.n1), .prod(nn11));
   cesd_mul u_nn22 (.clock, .en, .op_a(n_in.n2), .op_b(n_in.n2), .prod(nn22));
   cesd_mul u_nn01 (.clock, .en, .op_a(n_in.n0), .op_b(n_in.n1), .prod(nn01));
   cesd_mul u_nn02 (.clock, .en, .op_a(n_in.n0), .op_b(n_in.n2), .prod(nn02));
   cesd_mul u_nn12 (.clock, .en, .op_a(n_in.n2), .op_b(n_in.n1), .prod(nn12));
   cesd_mul u_musq (.clock, .en, .op_a(a3.mu), .op_b(sq), .prod(musq));
   cesd_mul u_tme0 (.clock, .en, .op_a(a3.twomu), .op_b(a3.e0), .prod(tme0));
   cesd_mul u_tme1 (.clock, .en, .op_a(a3.twomu), .op_b(a3.e1), .prod(tme1));
   cesd_mul u_tme2 (.clock, .en, .op_a(a3.twomu), .op_b(a3.e2), .prod(tme2));
   cesd_mul u_hls2 (.clock, .en, .op_a(a3.hl), .op_b(a3.s2), .prod(hls2));
   cesd_mul u_hls0 (.clock, .en, .op_a(a3.hl), .op_b(a3.s0), .prod(hls0));
   cesd_mul u_hls1 (.clock, .en, .op_a(a3.hl), .op_b(a3.s1), .prod(hls1));

   always_comb begin
      d6 = sat_sub(prod_m, Q_ONE);
      x0_op = a6.dim3 ? hls2 : a6.hl;
      c_in.d    = d6;
      c_in.nn01 = nn01;
      c_in.nn02 = nn02;
      c_in.nn12 = nn12;
      t_in.musq = musq;
      t_in.tme0 = tme0;
      t_in.tme1 = tme1;
      t_in.tme2 = tme2;
   end

   // round 3
   cesd_mul u_dd   (.clock, .en, .op_a(d6), .op_b(d6), .prod(dd));
   cesd_mul u_ld   (.clock, .en, .op_a(a6.lam), .op_b(d6), .prod(ld));
   cesd_mul u_sd2  (.clock, .en, .op_a(a6.s2), .op_b(d6), .prod(sd2));
   cesd_mul u_sd1  (.clock, .en, .op_a(a6.s1), .op_b(d6), .prod(sd1));
   cesd_mul u_sd0  (.clock, .en, .op_a(a6.s0), .op_b(d6), .prod(sd0));
   cesd_mul u_lnn0 (.clock, .en, .op_a(a6.lam), .op_b(nn00), .prod(lnn0));
   cesd_mul u_lnn1 (.clock, .en, .op_a(a6.lam), .op_b(nn11), .prod(lnn1));
   cesd_mul u_lnn2 (.clock, .en, .op_a(a6.lam), .op_b(nn22), .prod(lnn2));
   cesd_mul u_xd0  (.clock, .en, .op_a(x0_op), .op_b(d6), .prod(xd0));
   cesd_mul u_xd1  (.clock, .en, .op_a(hls0), .op_b(d6), .prod(xd1));
   cesd_mul u_xd2  (.clock, .en, .op_a(hls1), .op_b(d6), .prod(xd2));

   always_comb begin
      h01_op = a9.dim3 ? sd2 : c_pipe_ff[C_DELAY-1].d;
      l_in.lnn0 = lnn0;
      l_in.lnn1 = lnn1;
      l_in.lnn2 = lnn2;
      l_in.xd0  = xd0;
      l_in.xd1  = xd1;
      l_in.xd2  = xd2;
   end

   // round 4
   cesd_mul u_ldd  (.clock, .en, .op_a(a9.lam), .op_b(dd), .prod(ldd));
   cesd_mul u_nld0 (.clock, .en, .op_a(n_pipe_ff[N_DELAY-1].n0), .op_b(ld), .prod(nld0));
   cesd_mul u_nld1 (.clock, .en, .op_a(n_pipe_ff[N_DELAY-1].n1), .op_b(ld), .prod(nld1));
   cesd_mul u_nld2 (.clock, .en, .op_a(n_pipe_ff[N_DELAY-1].n2), .op_b(ld), .prod(nld2));
   cesd_mul u_h01  (.clock, .en, .op_a(a9.lam),
                    .op_b(sat_add(h01_op, c_pipe_ff[C_DELAY-1].nn01)), .prod(h01));
   cesd_mul u_h02  (.clock, .en, .op_a(a9.lam),
                    .op_b(sat_add(sd1, c_pipe_ff[C_DELAY-1].nn02)), .prod(h02));
   cesd_mul u_h12  (.clock, .en, .op_a(a9.lam),
                    .op_b(sat_add(sd0, c_pipe_ff[C_DELAY-1].nn12)), .prod(h12));

   // final sums
   always_comb begin
      res_in.energy = out48(sat_add(t_pipe_ff[T_DELAY-1].musq, half_q(ldd)));
      res_in.g0  = out48(sat_add(t_pipe_ff[T_DELAY-1].tme0, nld0));
      res_in.g1  = out48(sat_add(t_pipe_ff[T_DELAY-1].tme1, nld1));
      res_in.g2  = out48(sat_add(t_pipe_ff[T_DELAY-1].tme2, nld2));
      res_in.h00 = out48(sat_add(a12.twomu, l_pipe_ff[L_DELAY-1].lnn0));
      res_in.h11 = out48(sat_add(a12.twomu, l_pipe_ff[L_DELAY-1].lnn1));
      res_in.h22 = out48(sat_add(a12.twomu, l_pipe_ff[L_DELAY-1].lnn2));
      res_in.h01 = out48(h01);
      res_in.h02 = a12.dim3 ? out48(h02) : o_type'(0);
      res_in.h12 = a12.dim3 ? out48(h12) : o_type'(0);
      res_in.bl0 = out48(sat_sub(a12.mu, l_pipe_ff[L_DELAY-1].xd0));
      res_in.bl1 = a12.dim3 ? out48(sat_sub(a12.mu, l_pipe_ff[L_DELAY-1].xd1)) : o_type'(0);
      res_in.bl2 = out48(sat_sub(a12.mu, l_pipe_ff[L_DELAY-1].xd2));
      res_in.dim3 = a12.dim3;
   end

   // pipeline advance
   assign rsp_acc = obuf_v_ff && !rsp_stall;
   assign last = res_ff.dim3 ? (row_ff == ROW_LAST_3D) : (row_ff == ROW_LAST_2D);
   assign en = !obuf_v_ff || !v_ff[LAST_STAGE] || (rsp_acc && last);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAST_STAGE-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_pipe_ff[0] <= a_in;
         for (int k = 1; k <= LAST_STAGE; k++) begin
            a_pipe_ff[k] <= a_pipe_ff[k-1];
         end
         n_pipe_ff[0] <= n_in;
         for (int k = 1; k < N_DELAY; k++) begin
            n_pipe_ff[k] <= n_pipe_ff[k-1];
         end
         c_pipe_ff[0] <= c_in;
         for (int k = 1; k < C_DELAY; k++) begin
            c_pipe_ff[k] <= c_pipe_ff[k-1];
         end
         t_pipe_ff[0] <= t_in;
         for (int k = 1; k < T_DELAY; k++) begin
            t_pipe_ff[k] <= t_pipe_ff[k-1];
         end
         l_pipe_ff[0] <= l_in;
         for (int k = 1; k < L_DELAY; k++) begin
            l_pipe_ff[k] <= l_pipe_ff[k-1];
         end
      end
   end

   // output buffer, one result per transaction, presented row by row
   always_ff @(posedge clock) begin
      if (reset) begin
         obuf_v_ff <= 1'b0;
         row_ff    <= ROW_FIRST;
      end else if (en && v_ff[LAST_STAGE]) begin
         obuf_v_ff <= 1'b1;
         row_ff    <= ROW_FIRST;
      end else if (rsp_acc) begin
         if (last) begin
            obuf_v_ff <= 1'b0;
            row_ff    <= ROW_FIRST;
         end else begin
            row_ff <= row_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && v_ff[LAST_STAGE]) begin
         res_ff <= res_in;
      end
   end

   always_comb begin
      case (row_ff)
         ROW_FIRST: begin
            rsp_gradient      = res_ff.g0;
            rsp_hessian_col_a = res_ff.h00;
            rsp_hessian_col_b = res_ff.h01;
            rsp_hessian_col_c = res_ff.h02;
            rsp_bleft_coef    = res_ff.bl0;
         end
         ROW_LAST_2D: begin
            rsp_gradient      = res_ff.g1;
            rsp_hessian_col_a = res_ff.h01;
            rsp_hessian_col_b = res_ff.h11;
            rsp_hessian_col_c = res_ff.h12;
            rsp_bleft_coef    = res_ff.bl1;
         end
         default: begin
            rsp_gradient      = res_ff.g2;
            rsp_hessian_col_a = res_ff.h02;
            rsp_hessian_col_b = res_ff.h12;
            rsp_hessian_col_c = res_ff.h22;
            rsp_bleft_coef    = res_ff.bl2;
         end
      endcase
   end

   assign rsp_valid     = obuf_v_ff;
   assign rsp_row_index = row_ff;
   assign rsp_energy    = res_ff.energy;
   assign rsp_last_row  = last;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("pipeline stalled with empty output buffer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row_index == ROW_FIRST || rsp_row_index == ROW_LAST_2D
                     || rsp_row_index == ROW_LAST_3D))
      else $error("row index out of range");

   assert property (@(posedge clock) disable iff (reset)
      (req_stall && v_ff[LAST_STAGE]) |=> v_ff[LAST_STAGE])
      else $error("stalled element dropped from last stage");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_row && !v_ff[LAST_STAGE]) |=> !rsp_valid)
      else $error("row repeated after final transaction");

endmodule
